// ===== src/rcpd_pkg.sv =====
// Shared constants, rate type and scaling helpers for the receiver packet decoder.
package rcpd_pkg;

  localparam int unsigned PACKET_BYTES = 15;
  localparam int unsigned POS_W = $clog2(PACKET_BYTES);

  localparam logic OP_BYTE       = 1'b0;
  localparam logic OP_TIME_CHECK = 1'b1;

  localparam logic [POS_W-1:0] POS_HEADER   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_ID0      = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ID1      = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ZERO0    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_ZERO1    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_THROTTLE = POS_W'(5);
  localparam logic [POS_W-1:0] POS_YAW      = POS_W'(6);
  localparam logic [POS_W-1:0] POS_PITCH    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_ROLL     = POS_W'(8);
  localparam logic [POS_W-1:0] POS_FLAGS    = POS_W'(13);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(PACKET_BYTES - 1);

  localparam logic [7:0] HDR_DATA    = 8'h55;
  localparam logic [7:0] HDR_BIND    = 8'hAA;
  localparam logic [7:0] CHAN_OFFSET = 8'h7D;
  localparam logic [7:0] AXIS_CENTER = 8'h7F;
  localparam logic [7:0] YAW_POS_MAX = 8'h3C;

  localparam int unsigned FLAG_FULL_RATE = 6;
  localparam int unsigned FLAG_MID_RATE  = 5;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

  // Fixed-point division by the rate denominator uses a scaled reciprocal.
  localparam int unsigned RECIP_SHIFT = 29;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned NUM_W       = 20;

  localparam logic [RECIP_W-1:0] RECIP_60  = RECIP_W'(((64'd1 << RECIP_SHIFT) + 59) / 60);
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 99) / 100);
  localparam logic [RECIP_W-1:0] RECIP_300 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 299) / 300);

  typedef enum logic [1:0] {
    RATE_FULL,
    RATE_MID,
    RATE_LOW
  } rate_t;

  function automatic rate_t rate_of(input logic [7:0] flags_byte);
    rate_t r;
    if (flags_byte[FLAG_FULL_RATE]) begin
      r = RATE_FULL;
    end else if (flags_byte[FLAG_MID_RATE]) begin
      r = RATE_MID;
    end else begin
      r = RATE_LOW;
    end
    return r;
  endfunction

  function automatic logic [RECIP_W-1:0] recip_of(input rate_t rate);
    logic [RECIP_W-1:0] r;
    case (rate)
      RATE_FULL: r = RECIP_60;
      RATE_MID:  r = RECIP_100;
      RATE_LOW:  r = RECIP_300;
      default:   r = RECIP_300;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] half_of(input rate_t rate);
    logic [8:0] h;
    case (rate)
      RATE_FULL: h = 9'd30;
      RATE_MID:  h = 9'd50;
      RATE_LOW:  h = 9'd150;
      default:   h = 9'd150;
    endcase
    return h;
  endfunction

endpackage

// ===== src/rcpd_axis_scale.sv =====
// Converts one raw stick byte into a rate-scaled signed Q3.12 axis command.
module rcpd_axis_scale
  import rcpd_pkg::*;
(
  input  logic [7:0]  raw,
  input  logic        yaw_mode,
  input  rate_t       rate,
  output logic [15:0] scaled
);

  logic                      neg;
  logic [7:0]                mag;
  logic [NUM_W-1:0]          num;
  logic [NUM_W+RECIP_W-1:0]  prod;
  logic [14:0]               quot;

  always_comb begin
    if (raw[7]) begin
      neg = 1'b1;
      mag = raw - AXIS_CENTER;
    end else if (yaw_mode) begin
      neg = 1'b0;
      mag = (raw <= YAW_POS_MAX) ? raw : 8'd0;
    end else begin
      neg = 1'b0;
      mag = AXIS_CENTER - raw;
    end
  end

  // The magnitude is rounded half away from zero before the sign is applied.
  assign num    = {mag, 12'b0} + NUM_W'(half_of(rate));
  assign prod   = NUM_W'(num) * recip_of(rate);
  assign quot   = prod[RECIP_SHIFT +: 15];
  assign scaled = neg ? (16'd0 - {1'b0, quot}) : {1'b0, quot};

endmodule

// ===== src/rc_receiver_packet_decoder.sv =====
// Top level of the radio-control receiver packet decoder.
// Usage: each input request carries one packet byte (operation 0) or a bare
// time check (operation 1), with first_byte marking byte 0 of a 15-byte packet
// and now_us giving the current microsecond time.
// Every input request produces exactly one output request that shows the
// decoder state after that byte: held throttle and axes, aux flags, failsafe,
// bind status and, on the last byte of a bind packet, a radio channel write.
// The failsafe timeout is written through the configuration channel, which is
// always ready and must only be used while the decoder is idle.
// An accepted input request is held in the input register, which feeds one
// pass of decode logic into the output register that holds the result.
// Throughput is one request per cycle unless the output stalls; the three axis
// scalers each use one reciprocal multiply, which sets the longest path.
// Reset clears the decoder to bind mode with failsafe active and all axes at
// zero, and restores the default timeout of one second.
// When the output is stalled, the result holds and the input register keeps
// at most one further request before the input stops taking new ones.
module rc_receiver_packet_decoder
  import rcpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        failsafe_timeout_us,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic [31:0]        now_us,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         throttle,
  output logic signed [15:0] yaw,
  output logic signed [15:0] pitch,
  output logic signed [15:0] roll,
  output logic [3:0]         aux_flags,
  output logic [3:0]         aux_changed,
  output logic               packet_accepted,
  output logic               failsafe,
  output logic               bound,
  output logic               channel_write,
  output logic [7:0]         radio_channel
);

  logic [31:0]      timeout;

  logic             s1_valid;
  logic             s1_op;
  logic [7:0]       s1_byte;
  logic             s1_first;
  logic [31:0]      s1_now;
  logic             advance;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       packet_header, packet_header_next;
  logic             header_ok, header_ok_next;
  logic             normal_mode, normal_mode_next;
  logic [7:0]       transmitter_id [2];
  logic [7:0]       transmitter_id_next [2];
  logic [15:0]      pending_yaw, pending_yaw_next;
  logic [15:0]      pending_pitch, pending_pitch_next;
  logic [15:0]      pending_roll, pending_roll_next;
  logic [7:0]       pending_throttle, pending_throttle_next;
  logic [3:0]       pending_flags, pending_flags_next;
  logic [15:0]      held_yaw, held_yaw_next;
  logic [15:0]      held_pitch, held_pitch_next;
  logic [15:0]      held_roll, held_roll_next;
  logic [7:0]       held_throttle, held_throttle_next;
  logic [3:0]       previous_aux, previous_aux_next;
  logic [31:0]      last_good_time, last_good_time_next;
  logic             failsafe_flag, failsafe_flag_next;

  logic [POS_W-1:0] pos;
  logic             accepted;
  logic             chan_wr;
  logic [7:0]       channel;
  logic [3:0]       changed;
  logic [31:0]      elapsed;
  rate_t            rate;
  logic [15:0]      yaw_scaled, pitch_scaled, roll_scaled;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign rate      = rate_of(s1_byte);

  rcpd_axis_scale u_yaw (
    .raw      (pending_yaw[7:0]),
    .yaw_mode (1'b1),
    .rate     (rate),
    .scaled   (yaw_scaled)
  );

  rcpd_axis_scale u_pitch (
    .raw      (pending_pitch[7:0]),
    .yaw_mode (1'b0),
    .rate     (rate),
    .scaled   (pitch_scaled)
  );

  rcpd_axis_scale u_roll (
    .raw      (pending_roll[7:0]),
    .yaw_mode (1'b0),
    .rate     (rate),
    .scaled   (roll_scaled)
  );

  always_comb begin
    byte_position_next     = byte_position;
    packet_header_next     = packet_header;
    header_ok_next         = header_ok;
    normal_mode_next       = normal_mode;
    transmitter_id_next[0] = transmitter_id[0];
    transmitter_id_next[1] = transmitter_id[1];
    pending_yaw_next       = pending_yaw;
    pending_pitch_next     = pending_pitch;
    pending_roll_next      = pending_roll;
    pending_throttle_next  = pending_throttle;
    pending_flags_next     = pending_flags;
    held_yaw_next          = held_yaw;
    held_pitch_next        = held_pitch;
    held_roll_next         = held_roll;
    held_throttle_next     = held_throttle;
    previous_aux_next      = previous_aux;
    last_good_time_next    = last_good_time;
    failsafe_flag_next     = failsafe_flag;
    accepted               = 1'b0;
    chan_wr                = 1'b0;
    channel                = 8'd0;
    changed                = 4'd0;

    pos = s1_first ? POS_HEADER : byte_position;
    if (pos > POS_LAST) begin
      pos = POS_HEADER;
    end

    if (s1_op == OP_BYTE) begin
      if (pos == POS_HEADER) begin
        packet_header_next = s1_byte;
        header_ok_next     = (s1_byte == HDR_DATA);
      end else if (!normal_mode) begin
        if (packet_header == HDR_BIND && pos == POS_ID0) begin
          transmitter_id_next[0] = s1_byte;
        end else if (packet_header == HDR_BIND && pos == POS_ID1) begin
          transmitter_id_next[1] = s1_byte;
        end
      end else begin
        if ((pos == POS_ID0 && s1_byte != transmitter_id[0]) ||
            (pos == POS_ID1 && s1_byte != transmitter_id[1])) begin
          header_ok_next = 1'b0;
        end else if ((pos == POS_ZERO0 || pos == POS_ZERO1) && s1_byte != 8'd0) begin
          header_ok_next = 1'b0;
        end else if (pos == POS_THROTTLE) begin
          pending_throttle_next = s1_byte;
        end else if (pos == POS_YAW) begin
          pending_yaw_next = {8'd0, s1_byte};
        end else if (pos == POS_PITCH) begin
          pending_pitch_next = {8'd0, s1_byte};
        end else if (pos == POS_ROLL) begin
          pending_roll_next = {8'd0, s1_byte};
        end else if (pos == POS_FLAGS) begin
          pending_yaw_next   = yaw_scaled;
          pending_pitch_next = pitch_scaled;
          pending_roll_next  = roll_scaled;
          pending_flags_next = {s1_byte[4], s1_byte[3], s1_byte[2], s1_byte[0]};
        end
      end

      if (pos == POS_LAST) begin
        if (!normal_mode) begin
          if (packet_header == HDR_BIND) begin
            normal_mode_next = 1'b1;
            chan_wr          = 1'b1;
            channel          = transmitter_id[0] - CHAN_OFFSET;
          end
        end else if (header_ok) begin
          held_yaw_next       = pending_yaw;
          held_pitch_next     = pending_pitch;
          held_roll_next      = pending_roll;
          held_throttle_next  = pending_throttle;
          changed             = previous_aux ^ pending_flags;
          previous_aux_next   = pending_flags;
          last_good_time_next = s1_now;
          failsafe_flag_next  = 1'b0;
          accepted            = 1'b1;
        end
        header_ok_next = 1'b0;
      end

      byte_position_next = (pos == POS_LAST) ? POS_HEADER : pos + POS_W'(1);
    end

    elapsed = s1_now - last_good_time_next;
    if (elapsed > timeout) begin
      failsafe_flag_next = 1'b1;
      held_yaw_next      = 16'd0;
      held_pitch_next    = 16'd0;
      held_roll_next     = 16'd0;
      held_throttle_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= failsafe_timeout_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op    <= operation;
      s1_byte  <= data_byte;
      s1_first <= first_byte;
      s1_now   <= now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= POS_HEADER;
      packet_header     <= 8'd0;
      header_ok         <= 1'b0;
      normal_mode       <= 1'b0;
      transmitter_id[0] <= 8'd0;
      transmitter_id[1] <= 8'd0;
      pending_yaw       <= 16'd0;
      pending_pitch     <= 16'd0;
      pending_roll      <= 16'd0;
      pending_throttle  <= 8'd0;
      pending_flags     <= 4'd0;
      held_yaw          <= 16'd0;
      held_pitch        <= 16'd0;
      held_roll         <= 16'd0;
      held_throttle     <= 8'd0;
      previous_aux      <= 4'd0;
      last_good_time    <= 32'd0;
      failsafe_flag     <= 1'b1;
    end else if (advance) begin
      byte_position     <= byte_position_next;
      packet_header     <= packet_header_next;
      header_ok         <= header_ok_next;
      normal_mode       <= normal_mode_next;
      transmitter_id[0] <= transmitter_id_next[0];
      transmitter_id[1] <= transmitter_id_next[1];
      pending_yaw       <= pending_yaw_next;
      pending_pitch     <= pending_pitch_next;
      pending_roll      <= pending_roll_next;
      pending_throttle  <= pending_throttle_next;
      pending_flags     <= pending_flags_next;
      held_yaw          <= held_yaw_next;
      held_pitch        <= held_pitch_next;
      held_roll         <= held_roll_next;
      held_throttle     <= held_throttle_next;
      previous_aux      <= previous_aux_next;
      last_good_time    <= last_good_time_next;
      failsafe_flag     <= failsafe_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      throttle        <= held_throttle_next;
      yaw             <= held_yaw_next;
      pitch           <= held_pitch_next;
      roll            <= held_roll_next;
      aux_flags       <= previous_aux_next;
      aux_changed     <= changed;
      packet_accepted <= accepted;
      failsafe        <= failsafe_flag_next;
      bound           <= normal_mode_next;
      channel_write   <= chan_wr;
      radio_channel   <= channel;
    end
  end

endmodule

// ===== src/rcpd_checker.sv =====
// Port-level assertions for the receiver packet decoder and their bind.
module rcpd_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic [7:0]         throttle,
  input logic signed [15:0] yaw,
  input logic signed [15:0] pitch,
  input logic signed [15:0] roll,
  input logic [3:0]         aux_changed,
  input logic               packet_accepted,
  input logic               failsafe,
  input logic               bound,
  input logic               channel_write,
  input logic [7:0]         radio_channel
);

  // A channel write always leaves the decoder in normal mode.
  a_chan_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel_write |-> bound)
    else $error("channel write without normal mode");

  // An accepted data packet needs normal mode and clears failsafe.
  a_accept_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_accepted |-> bound && !failsafe && !channel_write)
    else $error("accepted packet with inconsistent status");

  // Failsafe always comes with zeroed commands.
  a_failsafe_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && failsafe |->
      throttle == 8'd0 && yaw == 16'sd0 && pitch == 16'sd0 && roll == 16'sd0)
    else $error("failsafe with nonzero commands");

  // Event-only fields are zero when their event is absent.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_accepted && !channel_write |->
      aux_changed == 4'd0 && radio_channel == 8'd0)
    else $error("event field set without its event");

endmodule

bind rc_receiver_packet_decoder rcpd_checker u_rcpd_checker (.*);

// ===== tb/rc_receiver_packet_decoder_tb.sv =====
// Testbench for the receiver packet decoder: directed and random byte streams checked by a scoreboard.
`timescale 1ns / 1ps

module rc_receiver_packet_decoder_tb
  import rcpd_pkg::*;
();

  localparam int DEN_FULL = 60;
  localparam int DEN_MID  = 100;
  localparam int DEN_LOW  = 300;
  localparam int Q_ONE    = 4096;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [7:0] packet_t [PACKET_BYTES];

  typedef struct {
    logic [7:0]  throttle;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [3:0]  aux_flags;
    logic [3:0]  aux_changed;
    logic        packet_accepted;
    logic        failsafe;
    logic        bound;
    logic        channel_write;
    logic [7:0]  radio_channel;
  } decoder_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] failsafe_timeout_us = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_BYTE;
  logic [7:0] data_byte = '0;
  logic first_byte = 1'b0;
  logic [31:0] now_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] throttle;
  logic signed [15:0] yaw;
  logic signed [15:0] pitch;
  logic signed [15:0] roll;
  logic [3:0] aux_flags;
  logic [3:0] aux_changed;
  logic packet_accepted;
  logic failsafe;
  logic bound;
  logic channel_write;
  logic [7:0] radio_channel;

  rc_receiver_packet_decoder uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .failsafe_timeout_us(failsafe_timeout_us),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .data_byte(data_byte),
    .first_byte(first_byte),
    .now_us(now_us),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .throttle(throttle),
    .yaw(yaw),
    .pitch(pitch),
    .roll(roll),
    .aux_flags(aux_flags),
    .aux_changed(aux_changed),
    .packet_accepted(packet_accepted),
    .failsafe(failsafe),
    .bound(bound),
    .channel_write(channel_write),
    .radio_channel(radio_channel)
  );

  class decoder_scoreboard;
    logic [31:0] timeout_us;
    int          position;
    logic [7:0]  header;
    bit          header_good;
    bit          bound_mode;
    logic [7:0]  tx_id [2];
    logic [15:0] pending_axes [4];
    logic [15:0] held_axes [4];
    logic [3:0]  pending_aux;
    logic [3:0]  last_aux;
    logic [31:0] last_good_us;
    bit          in_failsafe;
    int          failures;
    decoder_result_t pending_results [$];

    function new();
      timeout_us = TIMEOUT_RESET;
      position = 0;
      header = '0;
      header_good = 1'b0;
      bound_mode = 1'b0;
      tx_id = '{default: '0};
      pending_axes = '{default: '0};
      held_axes = '{default: '0};
      pending_aux = '0;
      last_aux = '0;
      last_good_us = '0;
      in_failsafe = 1'b1;
      failures = 0;
    endfunction

    function void set_timeout(logic [31:0] value);
      timeout_us = value;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function logic [15:0] scaled(int diff, int den);
      int mag;
      int q;
      mag = (diff < 0) ? -diff : diff;
      q = (mag * Q_ONE + den / 2) / den;
      return (diff < 0) ? 16'(-q) : 16'(q);
    endfunction

    function void scale_pending(logic [7:0] flags);
      int den;
      int ydiff;
      if (flags[FLAG_FULL_RATE]) begin
        den = DEN_FULL;
      end else if (flags[FLAG_MID_RATE]) begin
        den = DEN_MID;
      end else begin
        den = DEN_LOW;
      end
      if (pending_axes[0] >= 16'h80) begin
        ydiff = int'(AXIS_CENTER) - int'(pending_axes[0]);
      end else if (pending_axes[0] <= 16'(YAW_POS_MAX)) begin
        ydiff = int'(pending_axes[0]);
      end else begin
        ydiff = 0;
      end
      pending_axes[0] = scaled(ydiff, den);
      pending_axes[1] = scaled(int'(AXIS_CENTER) - int'(pending_axes[1][7:0]), den);
      pending_axes[2] = scaled(int'(AXIS_CENTER) - int'(pending_axes[2][7:0]), den);
      pending_aux = {flags[4], flags[3], flags[2], flags[0]};
    endfunction

    function void note_request(logic op, logic [7:0] b, logic first, logic [31:0] now);
      decoder_result_t e;
      int pos;
      logic [31:0] elapsed;
      e.packet_accepted = 1'b0;
      e.channel_write = 1'b0;
      e.radio_channel = '0;
      e.aux_changed = '0;
      if (op == OP_BYTE) begin
        pos = first ? 0 : position;
        if (pos >= PACKET_BYTES) begin
          pos = 0;
        end
        if (pos == POS_HEADER) begin
          header = b;
          header_good = (b == HDR_DATA);
        end else if (!bound_mode) begin
          if (header == HDR_BIND && (pos == POS_ID0 || pos == POS_ID1)) begin
            tx_id[pos - 1] = b;
          end
        end else begin
          if ((pos == POS_ID0 || pos == POS_ID1) && b != tx_id[pos - 1]) begin
            header_good = 1'b0;
          end else if ((pos == POS_ZERO0 || pos == POS_ZERO1) && b != 8'h00) begin
            header_good = 1'b0;
          end else if (pos == POS_THROTTLE) begin
            pending_axes[3] = 16'(b);
          end else if (pos >= POS_YAW && pos <= POS_ROLL) begin
            pending_axes[pos - POS_YAW] = 16'(b);
          end else if (pos == POS_FLAGS) begin
            scale_pending(b);
          end
        end
        if (pos == POS_LAST) begin
          if (!bound_mode) begin
            if (header == HDR_BIND) begin
              bound_mode = 1'b1;
              e.channel_write = 1'b1;
              e.radio_channel = tx_id[0] - CHAN_OFFSET;
            end
          end else if (header_good) begin
            held_axes = pending_axes;
            e.aux_changed = last_aux ^ pending_aux;
            last_aux = pending_aux;
            last_good_us = now;
            in_failsafe = 1'b0;
            e.packet_accepted = 1'b1;
          end
          header_good = 1'b0;
        end
        position = (pos + 1 >= PACKET_BYTES) ? 0 : pos + 1;
      end
      elapsed = now - last_good_us;
      if (elapsed > timeout_us) begin
        in_failsafe = 1'b1;
        held_axes = '{default: '0};
      end
      e.throttle = held_axes[3][7:0];
      e.yaw = held_axes[0];
      e.pitch = held_axes[1];
      e.roll = held_axes[2];
      e.aux_flags = last_aux;
      e.failsafe = in_failsafe;
      e.bound = bound_mode;
      pending_results.push_back(e);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        failures++;
      end
    endfunction

    function void check_result(decoder_result_t got);
      decoder_result_t want;
      if (pending_results.size() == 0) begin
        $error("output request with no input request outstanding");
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("throttle", 16'(want.throttle), 16'(got.throttle));
      compare_field("yaw", want.yaw, got.yaw);
      compare_field("pitch", want.pitch, got.pitch);
      compare_field("roll", want.roll, got.roll);
      compare_field("aux_flags", 16'(want.aux_flags), 16'(got.aux_flags));
      compare_field("aux_changed", 16'(want.aux_changed), 16'(got.aux_changed));
      compare_field("packet_accepted", 16'(want.packet_accepted), 16'(got.packet_accepted));
      compare_field("failsafe", 16'(want.failsafe), 16'(got.failsafe));
      compare_field("bound", 16'(want.bound), 16'(got.bound));
      compare_field("channel_write", 16'(want.channel_write), 16'(got.channel_write));
      compare_field("radio_channel", 16'(want.radio_channel), 16'(got.radio_channel));
    endfunction
  endclass

  decoder_scoreboard sb;
  logic [31:0] now_val = '0;
  logic [31:0] timeout_val = TIMEOUT_RESET;
  logic [7:0] id0 = 8'h7C;
  logic [7:0] id1 = 8'hE3;
  bit idle_en = 1'b1;
  bit aligned = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void advance_time();
    int unsigned roll_pick;
    logic [31:0] span;
    roll_pick = $urandom_range(0, 99);
    span = (timeout_val > 32'h3FFF_FFFF) ? 32'hFFFF_FFFF : timeout_val * 2 + 2;
    if (roll_pick < 2) begin
      now_val = $urandom;
    end else if (roll_pick < 12) begin
      now_val = now_val + $urandom_range(0, span);
    end else begin
      now_val = now_val + $urandom_range(0, 3);
    end
  endfunction

  function automatic logic [7:0] pick_axis();
    logic [7:0] corners [6] = '{8'h00, 8'h3C, 8'h3D, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 2) == 0) begin
      return corners[$urandom_range(0, 5)];
    end
    return 8'($urandom);
  endfunction

  function automatic packet_t make_data_packet();
    packet_t pkt;
    foreach (pkt[i]) begin
      pkt[i] = 8'($urandom);
    end
    pkt[POS_HEADER] = HDR_DATA;
    pkt[POS_ID0] = id0;
    pkt[POS_ID1] = id1;
    pkt[POS_ZERO0] = 8'h00;
    pkt[POS_ZERO1] = 8'h00;
    pkt[POS_THROTTLE] = pick_axis();
    pkt[POS_YAW] = pick_axis();
    pkt[POS_PITCH] = pick_axis();
    pkt[POS_ROLL] = pick_axis();
    return pkt;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b, input logic fb);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    advance_time();
    in_valid <= 1'b1;
    operation <= op;
    data_byte <= b;
    first_byte <= fb;
    now_us <= now_val;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, b, fb, now_val);
    items_sent++;
  endtask

  task automatic send_bytes(input packet_t pkt, input int len, input bit mark_first);
    for (int i = 0; i < len; i++) begin
      send_item(OP_BYTE, pkt[i], (i == 0) && mark_first);
    end
  endtask

  task automatic send_time_checks(input int count);
    repeat (count) begin
      send_item(OP_TIME_CHECK, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic write_timeout(input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    failsafe_timeout_us <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_timeout(value);
    timeout_val = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int target;
    int kind;
    packet_t pkt;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      pkt = make_data_packet();
      if (kind < 70) begin
        send_bytes(pkt, PACKET_BYTES, aligned ? ($urandom_range(0, 3) != 0) : 1'b1);
        aligned = 1'b1;
      end else if (kind < 78) begin
        case ($urandom_range(0, 3))
          0: begin
            pkt[POS_HEADER] = 8'($urandom);
            if (pkt[POS_HEADER] == HDR_DATA) begin
              pkt[POS_HEADER] = ~HDR_DATA;
            end
          end
          1: pkt[POS_ID0] = pkt[POS_ID0] ^ 8'($urandom_range(1, 255));
          2: pkt[POS_ID1] = pkt[POS_ID1] ^ 8'($urandom_range(1, 255));
          default: pkt[POS_ZERO0 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
        endcase
        send_bytes(pkt, PACKET_BYTES, 1'b1);
        aligned = 1'b1;
      end else if (kind < 86) begin
        send_bytes(pkt, $urandom_range(1, PACKET_BYTES - 1), 1'b1);
        aligned = 1'b0;
      end else if (kind < 94) begin
        send_time_checks($urandom_range(1, 3));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_item(OP_BYTE, 8'($urandom), $urandom_range(0, 3) == 0);
        end
        aligned = 1'b0;
      end
    end
  endtask

  task automatic run_directed();
    packet_t pkt;
    send_time_checks(1);
    // A data header while unbound must not bind or decode anything.
    pkt = make_data_packet();
    send_bytes(pkt, 4, 1'b1);
    // Partial bind packet writes the id bytes but leaves the mode alone.
    pkt[POS_HEADER] = HDR_BIND;
    pkt[POS_ID0] = 8'h11;
    pkt[POS_ID1] = 8'h22;
    send_bytes(pkt, 3, 1'b1);
    // Full bind packet; the first id byte makes the channel wrap below zero.
    pkt = make_data_packet();
    pkt[POS_HEADER] = HDR_BIND;
    send_bytes(pkt, PACKET_BYTES, 1'b1);
    pkt = make_data_packet();
    pkt[POS_THROTTLE] = 8'hFF;
    pkt[POS_YAW] = YAW_POS_MAX;
    pkt[POS_PITCH] = 8'h00;
    pkt[POS_ROLL] = 8'hFF;
    pkt[POS_FLAGS] = 8'h5D;
    send_bytes(pkt, PACKET_BYTES, 1'b1);
    aligned = 1'b1;
    send_time_checks(1);
  endtask

  always @(negedge clk) begin
    out_ready <= !(idle_en && $urandom_range(0, 99) < 6);
  end

  always @(posedge clk) begin : result_monitor
    decoder_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.throttle = throttle;
      got.yaw = yaw;
      got.pitch = pitch;
      got.roll = roll;
      got.aux_flags = aux_flags;
      got.aux_changed = aux_changed;
      got.packet_accepted = packet_accepted;
      got.failsafe = failsafe;
      got.bound = bound;
      got.channel_write = channel_write;
      got.radio_channel = radio_channel;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(130);
    settle();

    // Largest timeout, with no idling on either side.
    write_timeout(32'hFFFF_FFFF);
    idle_en = 1'b0;
    run_random(200);
    settle();

    idle_en = 1'b1;
    write_timeout(32'd1);
    run_random(200);
    settle();

    // Mid-range timeout with the time stamp about to wrap.
    write_timeout($urandom_range(200, 3000));
    now_val = 32'hFFFF_F000;
    run_random(250);
    settle();

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
